/* sv/positional_sequence_store_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the positional sequence store
// Shorthand for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_SEQUENCE_STORE_MACROS_SVH
`define POSITIONAL_SEQUENCE_STORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PSS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pss check failed");

// next-cycle implication
`define PSS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pss check failed");

`endif

/* sv/pss_pkg.sv */
// ----------------------------------------------------------------------------
// pss_pkg
// Shared widths, codes and types of the positional sequence store.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int POSA_W    = 6;
    localparam int POSB_W    = 5;
    localparam int AMT_W     = 16;
    localparam int AMT_CNT_W = 4;
    localparam int STAT_W    = 3;

    localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DUMP    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_MOVE    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_REVERSE = 3'd4;
    localparam logic [FUNC_W-1:0] FN_ROTL    = 3'd5;
    localparam logic [FUNC_W-1:0] FN_ROTR    = 3'd6;

    localparam logic [STAT_W-1:0] ST_DONE   = 3'd0;
    localparam logic [STAT_W-1:0] ST_ELEM   = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_STEP,
        S_DUMP
    } state_t;

    // one segment rotation by a single place across the cell row
    typedef struct packed {
        logic en;
        logic left;
        logic inject;
    } seg_ctl_t;

endpackage

/* sv/pss_cmd_if.sv */
// ----------------------------------------------------------------------------
// pss_cmd_if
// Command channel: valid/ready handshake with the command fields.
// ----------------------------------------------------------------------------
interface pss_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [pss_pkg::FUNC_W-1:0]           func;
    logic signed [pss_pkg::DATA_W-1:0]    value;
    logic [pss_pkg::POSA_W-1:0]           pos_a;
    logic [pss_pkg::POSB_W-1:0]           pos_b;
    logic [pss_pkg::AMT_W-1:0]            shift_amount;

    modport source (output valid, func, value, pos_a, pos_b, shift_amount, input ready);
    modport sink   (input valid, func, value, pos_a, pos_b, shift_amount, output ready);
endinterface

/* sv/pss_res_if.sv */
// ----------------------------------------------------------------------------
// pss_res_if
// Result channel: valid/ready handshake with status, element and last.
// ----------------------------------------------------------------------------
interface pss_res_if;
    logic                                 valid;
    logic                                 ready;
    logic [pss_pkg::STAT_W-1:0]           status;
    logic signed [pss_pkg::DATA_W-1:0]    element;
    logic                                 last;

    modport source (output valid, status, element, last, input ready);
    modport sink   (input valid, status, element, last, output ready);
endinterface

/* sv/pss_cell.sv */
// ----------------------------------------------------------------------------
// pss_cell
// One storage cell of the row: holds, or takes a neighbour or the wrap value.
// ----------------------------------------------------------------------------
module pss_cell #(
    parameter int AW  = 5,
    parameter int IDX = 0
) (
    input  logic                              clk,
    input  pss_pkg::seg_ctl_t                 ctl,
    input  logic [AW-1:0]                     lo,
    input  logic [AW-1:0]                     hi,
    input  logic signed [pss_pkg::DATA_W-1:0] left_nb,
    input  logic signed [pss_pkg::DATA_W-1:0] right_nb,
    input  logic signed [pss_pkg::DATA_W-1:0] wrap,
    output logic signed [pss_pkg::DATA_W-1:0] value
);

    localparam logic [AW-1:0] MY_IDX = AW'(IDX);

    logic signed [pss_pkg::DATA_W-1:0] value_reg;
    logic signed [pss_pkg::DATA_W-1:0] value_next;
    logic                              in_seg;

    assign in_seg = ctl.en && (MY_IDX >= lo) && (MY_IDX <= hi);

    always_comb
    begin
        value_next = value_reg;
        if (in_seg)
        begin
            if (ctl.left)
            begin
                value_next = (MY_IDX == hi) ? wrap : right_nb;
            end
            else
            begin
                value_next = (MY_IDX == lo) ? wrap : left_nb;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

/* sv/pss_ctrl.sv */
// ----------------------------------------------------------------------------
// pss_ctrl
// Command decode, rotation modulo unit, step sequencer and result register.
// ----------------------------------------------------------------------------
module pss_ctrl #(
    parameter int DEPTH = pss_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    pss_cmd_if.sink                           cmd,
    pss_res_if.source                         res,
    input  logic signed [pss_pkg::DATA_W-1:0] head_val,
    output pss_pkg::seg_ctl_t                 ctl,
    output logic [$clog2(DEPTH)-1:0]          lo,
    output logic [$clog2(DEPTH)-1:0]          hi,
    output logic signed [pss_pkg::DATA_W-1:0] ins_val
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    pss_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                     count_reg, count_next;
    logic [CW-1:0]                     steps_reg, steps_next;
    logic [AW-1:0]                     lo_reg, lo_next;
    logic [AW-1:0]                     hi_reg, hi_next;
    logic                              left_reg, left_next;
    logic                              inject_reg, inject_next;
    logic                              lo_inc_reg, lo_inc_next;
    logic                              rot_left_reg, rot_left_next;
    logic [CW-1:0]                     rem_reg, rem_next;
    logic [pss_pkg::AMT_W-1:0]         amt_reg, amt_next;
    logic [pss_pkg::AMT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic signed [pss_pkg::DATA_W-1:0] ins_val_reg, ins_val_next;

    logic                              out_valid_reg, out_valid_next;
    logic [pss_pkg::STAT_W-1:0]        out_status_reg, out_status_next;
    logic signed [pss_pkg::DATA_W-1:0] out_elem_reg, out_elem_next;
    logic                              out_last_reg, out_last_next;

    logic          slot_free;
    logic          accept;
    logic [31:0]   pa_ext, pb_ext, cnt_ext;
    logic [CW-1:0] cnt_m1;
    logic [CW:0]   rem_shift;
    logic [CW-1:0] rem_new;
    logic          mod_last;

    // decode of the command at acceptance
    logic [pss_pkg::STAT_W-1:0] dec_status;
    logic          go_step, go_mod, go_dump;
    logic          dec_inc, dec_dec;
    logic [AW-1:0] dec_lo, dec_hi;
    logic          dec_left, dec_inject, dec_lo_inc;
    logic [CW-1:0] dec_steps;

    assign slot_free = !out_valid_reg || res.ready;
    assign cmd.ready = (state_reg == pss_pkg::S_IDLE) && slot_free;
    assign accept    = cmd.valid && cmd.ready;

    assign pa_ext  = 32'(cmd.pos_a);
    assign pb_ext  = 32'(cmd.pos_b);
    assign cnt_ext = 32'(count_reg);
    assign cnt_m1  = count_reg - CW'(1);

    // restoring remainder, one bit of the amount per cycle
    assign rem_shift = {rem_reg, amt_reg[pss_pkg::AMT_W-1]};
    assign rem_new   = (rem_shift >= {1'b0, count_reg}) ? CW'(rem_shift - {1'b0, count_reg})
                                                        : CW'(rem_shift);
    assign mod_last  = (bit_cnt_reg == '1);

    always_comb
    begin
        dec_status = pss_pkg::ST_DONE;
        go_step    = 1'b0;
        go_mod     = 1'b0;
        go_dump    = 1'b0;
        dec_inc    = 1'b0;
        dec_dec    = 1'b0;
        dec_lo     = '0;
        dec_hi     = AW'(cnt_m1);
        dec_left   = 1'b1;
        dec_inject = 1'b0;
        dec_lo_inc = 1'b0;
        dec_steps  = CW'(1);
        case (cmd.func)
            pss_pkg::FN_INSERT:
            begin
                if (pa_ext > cnt_ext)
                begin
                    dec_status = pss_pkg::ST_BADPOS;
                end
                else if (cnt_ext >= 32'(DEPTH))
                begin
                    dec_status = pss_pkg::ST_FULL;
                end
                else
                begin
                    go_step    = 1'b1;
                    dec_inc    = 1'b1;
                    dec_lo     = AW'(cmd.pos_a);
                    dec_hi     = AW'(count_reg);
                    dec_left   = 1'b0;
                    dec_inject = 1'b1;
                end
            end
            pss_pkg::FN_REMOVE:
            begin
                if (pa_ext >= cnt_ext)
                begin
                    dec_status = pss_pkg::ST_BADPOS;
                end
                else
                begin
                    go_step = 1'b1;
                    dec_dec = 1'b1;
                    dec_lo  = AW'(cmd.pos_a);
                end
            end
            pss_pkg::FN_DUMP:
            begin
                if (count_reg == '0)
                begin
                    dec_status = pss_pkg::ST_EMPTY;
                end
                else
                begin
                    go_dump   = 1'b1;
                    dec_steps = count_reg;
                end
            end
            pss_pkg::FN_MOVE:
            begin
                if (pa_ext >= cnt_ext || pb_ext >= cnt_ext)
                begin
                    dec_status = pss_pkg::ST_BADPOS;
                end
                else if (pa_ext != pb_ext)
                begin
                    go_step = 1'b1;
                    if (pa_ext < pb_ext)
                    begin
                        dec_lo = AW'(cmd.pos_a);
                        dec_hi = AW'(cmd.pos_b);
                    end
                    else
                    begin
                        dec_lo   = AW'(cmd.pos_b);
                        dec_hi   = AW'(cmd.pos_a);
                        dec_left = 1'b0;
                    end
                end
            end
            pss_pkg::FN_REVERSE:
            begin
                // pull the tail into place j, then shrink the segment from the front
                if (cnt_ext > 32'd1)
                begin
                    go_step    = 1'b1;
                    dec_left   = 1'b0;
                    dec_lo_inc = 1'b1;
                    dec_steps  = cnt_m1;
                end
            end
            pss_pkg::FN_ROTL, pss_pkg::FN_ROTR:
            begin
                go_mod = (cnt_ext > 32'd1);
            end
            default:
            begin
                dec_status = pss_pkg::ST_DONE;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pss_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (go_step)
                    begin
                        state_next = pss_pkg::S_STEP;
                    end
                    else if (go_mod)
                    begin
                        state_next = pss_pkg::S_MOD;
                    end
                    else if (go_dump)
                    begin
                        state_next = pss_pkg::S_DUMP;
                    end
                end
            end
            pss_pkg::S_MOD:
            begin
                if (mod_last)
                begin
                    state_next = (rem_new == '0) ? pss_pkg::S_IDLE : pss_pkg::S_STEP;
                end
            end
            pss_pkg::S_STEP:
            begin
                if (steps_reg == CW'(1))
                begin
                    state_next = pss_pkg::S_IDLE;
                end
            end
            pss_pkg::S_DUMP:
            begin
                if (slot_free && steps_reg == CW'(1))
                begin
                    state_next = pss_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pss_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next      = count_reg;
        steps_next      = steps_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        left_next       = left_reg;
        inject_next     = inject_reg;
        lo_inc_next     = lo_inc_reg;
        rot_left_next   = rot_left_reg;
        rem_next        = rem_reg;
        amt_next        = amt_reg;
        bit_cnt_next    = bit_cnt_reg;
        ins_val_next    = ins_val_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_status_next = out_status_reg;
        out_elem_next   = out_elem_reg;
        out_last_next   = out_last_reg;
        ctl.en          = 1'b0;
        ctl.left        = left_reg;
        ctl.inject      = inject_reg;
        case (state_reg)
            pss_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    ins_val_next  = cmd.value;
                    lo_next       = dec_lo;
                    hi_next       = dec_hi;
                    left_next     = dec_left;
                    inject_next   = dec_inject;
                    lo_inc_next   = dec_lo_inc;
                    steps_next    = dec_steps;
                    rem_next      = '0;
                    amt_next      = cmd.shift_amount;
                    bit_cnt_next  = '0;
                    rot_left_next = (cmd.func == pss_pkg::FN_ROTL);
                    if (dec_inc)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else if (dec_dec)
                    begin
                        count_next = cnt_m1;
                    end
                    if (!go_step && !go_mod && !go_dump)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = dec_status;
                        out_elem_next   = '0;
                        out_last_next   = 1'b1;
                    end
                end
            end
            pss_pkg::S_MOD:
            begin
                rem_next     = rem_new;
                amt_next     = amt_reg << 1;
                bit_cnt_next = bit_cnt_reg + pss_pkg::AMT_CNT_W'(1);
                if (mod_last)
                begin
                    // right rotation by k is left rotation by count - k
                    steps_next  = rot_left_reg ? rem_new : count_reg - rem_new;
                    lo_next     = '0;
                    hi_next     = AW'(cnt_m1);
                    left_next   = 1'b1;
                    inject_next = 1'b0;
                    lo_inc_next = 1'b0;
                    if (rem_new == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = pss_pkg::ST_DONE;
                        out_elem_next   = '0;
                        out_last_next   = 1'b1;
                    end
                end
            end
            pss_pkg::S_STEP:
            begin
                ctl.en     = 1'b1;
                steps_next = steps_reg - CW'(1);
                lo_next    = lo_reg + AW'(lo_inc_reg);
                if (steps_reg == CW'(1))
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pss_pkg::ST_DONE;
                    out_elem_next   = '0;
                    out_last_next   = 1'b1;
                end
            end
            pss_pkg::S_DUMP:
            begin
                // emit the head and rotate left; count rotations restore the order
                if (slot_free)
                begin
                    ctl.en          = 1'b1;
                    steps_next      = steps_reg - CW'(1);
                    out_valid_next  = 1'b1;
                    out_status_next = pss_pkg::ST_ELEM;
                    out_elem_next   = head_val;
                    out_last_next   = (steps_reg == CW'(1));
                end
            end
            default:
            begin
                ctl.en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pss_pkg::S_IDLE;
            count_reg     <= '0;
            steps_reg     <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            steps_reg     <= steps_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        left_reg       <= left_next;
        inject_reg     <= inject_next;
        lo_inc_reg     <= lo_inc_next;
        rot_left_reg   <= rot_left_next;
        rem_reg        <= rem_next;
        amt_reg        <= amt_next;
        ins_val_reg    <= ins_val_next;
        out_status_reg <= out_status_next;
        out_elem_reg   <= out_elem_next;
        out_last_reg   <= out_last_next;
    end

    assign lo          = lo_reg;
    assign hi          = hi_reg;
    assign ins_val     = ins_val_reg;
    assign res.valid   = out_valid_reg;
    assign res.status  = out_status_reg;
    assign res.element = out_elem_reg;
    assign res.last    = out_last_reg;

endmodule

/* sv/positional_sequence_store.sv */
// Flagged and no-op commands are answered from the decode; insert, remove and move make one
// single-place step across the cell row. Reverse steps along a segment that shrinks from the
// front; rotate runs the modulo unit one amount bit at a time, then rotates left in single-place
// steps. Dump emits the head and rotates left per element while the output is free. One command at a time: the
// next one is taken once the last result of the one before is leaving the output register.
// Reset clears the count and control; cell contents are undefined.
// ----------------------------------------------------------------------------
// positional_sequence_store
// Ordered store of signed values kept in a row of shifting cells.
// ----------------------------------------------------------------------------
module positional_sequence_store #(
    parameter int DEPTH = pss_pkg::DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pss_cmd_if.sink   cmd,
    pss_res_if.source res
);

    localparam int AW = $clog2(DEPTH);

    pss_pkg::seg_ctl_t                 ctl;
    logic [AW-1:0]                     lo, hi, rd_idx;
    logic signed [pss_pkg::DATA_W-1:0] ins_val;
    logic signed [pss_pkg::DATA_W-1:0] wrap;
    logic signed [pss_pkg::DATA_W-1:0] cell_val [DEPTH];

    pss_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .res      (res),
        .head_val (cell_val[0]),
        .ctl      (ctl),
        .lo       (lo),
        .hi       (hi),
        .ins_val  (ins_val)
    );

    // value that wraps into the open end of the segment
    assign rd_idx = ctl.left ? lo : hi;
    assign wrap   = ctl.inject ? ins_val : cell_val[rd_idx];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        pss_cell #(
            .AW  (AW),
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .lo       (lo),
            .hi       (hi),
            .left_nb  (cell_val[(i > 0) ? i - 1 : 0]),
            .right_nb (cell_val[(i < DEPTH - 1) ? i + 1 : DEPTH - 1]),
            .wrap     (wrap),
            .value    (cell_val[i])
        );
    end

endmodule

/* sv/pss_checker.sv */
// ----------------------------------------------------------------------------
// pss_checker
// Port-level checks on the store, bound to the top level.
// ----------------------------------------------------------------------------
`include "positional_sequence_store_macros.svh"

module pss_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cmd_valid,
    input logic                              cmd_ready,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic [pss_pkg::STAT_W-1:0]        res_status,
    input logic signed [pss_pkg::DATA_W-1:0] res_element,
    input logic                              res_last
);

    // a stalled result item holds
`PSS_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_element) && $stable(res_last))

    // no command is taken in the middle of a dump
`PSS_ASSERT_IMP(a_no_cmd_mid_dump, res_valid && res_status == pss_pkg::ST_ELEM && !res_last, !cmd_ready)

    // anything but an element is a lone, zero-valued final item
`PSS_ASSERT_IMP(a_single_result, res_valid && res_status != pss_pkg::ST_ELEM, res_last && res_element == '0)

endmodule

bind positional_sequence_store pss_checker u_pss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_status  (res.status),
    .res_element (res.element),
    .res_last    (res.last)
);
